FILE: src/stcp_pkg.sv
// Package: shared constants, types and digit/character helpers for the serial time-code port.
`timescale 1ns / 1ps

package stcp_pkg;

   // Bus access kind, unit select and register select codes.
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;
   localparam logic UNIT_RX    = 1'b0;
   localparam logic UNIT_TX    = 1'b1;
   localparam logic REG_CSR    = 1'b0;
   localparam logic REG_BUF    = 1'b1;

   localparam int unsigned STR_LEN  = 26;
   localparam logic [4:0]  LAST_POS = 5'(STR_LEN - 1);

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   localparam int unsigned CSR_ENABLE_BIT = 6;

   // Decimal digits of the latched time, one nibble each.
   typedef struct packed {
      logic [3:0] day_h;
      logic [3:0] day_t;
      logic [3:0] day_o;
      logic [3:0] hour_t;
      logic [3:0] hour_o;
      logic [3:0] min_t;
      logic [3:0] min_o;
      logic [3:0] sec_t;
      logic [3:0] sec_o;
   } time_digits_type;

   // Quotient by 10 for values up to 511, by reciprocal multiply.
   function automatic logic [5:0] div10_9(input logic [8:0] v);
      logic [16:0] p;
      p = {8'b0, v} * 17'd205;
      return p[16:11];
   endfunction

   // Quotient by 100 for values up to 511.
   function automatic logic [2:0] div100_9(input logic [8:0] v);
      logic [14:0] p;
      p = {6'b0, v} * 15'd41;
      return p[14:12];
   endfunction

   // Quotient by 10 for values up to 63.
   function automatic logic [2:0] div10_6(input logic [5:0] v);
      logic [9:0] p;
      p = {4'b0, v} * 10'd13;
      return p[9:7];
   endfunction

   // Remainder by 10 for values up to 63.
   function automatic logic [3:0] mod10_6(input logic [5:0] v);
      logic [5:0] m;
      logic [5:0] r;
      m = {3'b0, div10_6(v)} * 6'd10;
      r = v - m;
      return r[3:0];
   endfunction

   function automatic time_digits_type make_digits(input logic [8:0] day,
                                                  input logic [4:0] hour,
                                                  input logic [5:0] minute,
                                                  input logic [5:0] second);
      time_digits_type d;
      logic [5:0] day_q;
      logic [8:0] day_m;
      logic [8:0] day_r;
      day_q    = div10_9(day);
      day_m    = {3'b0, day_q} * 9'd10;
      day_r    = day - day_m;
      d.day_h  = {1'b0, div100_9(day)};
      d.day_t  = mod10_6(day_q);
      d.day_o  = day_r[3:0];
      d.hour_t = {1'b0, div10_6({1'b0, hour})};
      d.hour_o = mod10_6({1'b0, hour});
      d.min_t  = {1'b0, div10_6(minute)};
      d.min_o  = mod10_6(minute);
      d.sec_t  = {1'b0, div10_6(second)};
      d.sec_o  = mod10_6(second);
      return d;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      return CHAR_ZERO + {4'b0, d};
   endfunction

   function automatic logic [7:0] char_at(input logic [4:0] pos,
                                          input time_digits_type d);
      logic [7:0] c;
      unique case (pos) inside
         5'd0, 5'd24:  c = CHAR_CR;
         5'd1, 5'd25:  c = CHAR_LF;
         5'd5:         c = digit_char(d.day_h);
         5'd6:         c = digit_char(d.day_t);
         5'd7:         c = digit_char(d.day_o);
         5'd9:         c = digit_char(d.hour_t);
         5'd10:        c = digit_char(d.hour_o);
         5'd11, 5'd14: c = CHAR_COLON;
         5'd12:        c = digit_char(d.min_t);
         5'd13:        c = digit_char(d.min_o);
         5'd15:        c = digit_char(d.sec_t);
         5'd16:        c = digit_char(d.sec_o);
         5'd19:        c = CHAR_T;
         5'd20:        c = CHAR_Z;
         5'd21:        c = CHAR_EQ;
         5'd22, 5'd23: c = CHAR_ZERO;
         default:      c = CHAR_SPACE;
      endcase
      return c;
   endfunction

endpackage

FILE: src/stcp_req_if.sv
// Interface: bus access channel into the serial time-code port.
`timescale 1ns / 1ps

interface stcp_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic        unit_sel;
   logic        reg_sel;
   logic        byte_high;
   logic [15:0] write_data;
   logic [8:0]  day_of_year;
   logic [4:0]  hour_now;
   logic [5:0]  minute_now;
   logic [5:0]  second_now;

   modport source (
      output valid, func, unit_sel, reg_sel, byte_high, write_data,
             day_of_year, hour_now, minute_now, second_now,
      input  ready
   );
   modport sink (
      input  valid, func, unit_sel, reg_sel, byte_high, write_data,
             day_of_year, hour_now, minute_now, second_now,
      output ready
   );
endinterface

FILE: src/stcp_rsp_if.sv
// Interface: access result channel out of the serial time-code port.
`timescale 1ns / 1ps

interface stcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       rx_irq;
   logic       tx_irq;

   modport source (output valid, read_data, rx_irq, tx_irq, input ready);
   modport sink (input valid, read_data, rx_irq, tx_irq, output ready);
endinterface

FILE: src/serial_time_code_port.sv
// Top level: serial time-code port with receive/transmit CSR and buffer pairs.
`timescale 1ns / 1ps

//  channel   | direction | handshake    | payload
//  req_chan  | in        | valid/ready  | func, unit_sel, reg_sel, byte_high, write_data, time
//  rsp_chan  | out       | valid/ready  | read_data, rx_irq, tx_irq
//
// Each transaction is decoded and applied in the cycle it is accepted; its result
// sits in the output register from the next cycle, so one transaction per cycle while
// rsp_chan.ready is high. The single output register sets that rate: req_chan.ready is
// low only during reset and while a result is held and rsp_chan.ready is low.
// Synchronous reset: both sides idle, transmit done set, no time string loaded.

module serial_time_code_port (
   input  logic            clock,
   input  logic            reset,
   stcp_req_if.sink        req_chan,
   stcp_rsp_if.source      rsp_chan
);

   logic rx_done_ff, rx_done_in;
   logic rx_enable_ff, rx_enable_in;
   logic rx_pending_ff, rx_pending_in;
   logic tx_done_ff, tx_done_in;
   logic tx_enable_ff, tx_enable_in;
   logic tx_pending_ff, tx_pending_in;
   logic [7:0] tx_byte_ff, tx_byte_in;
   logic string_loaded_ff, string_loaded_in;
   logic [4:0] char_index_ff, char_index_in;
   stcp_pkg::time_digits_type digits_ff, digits_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] read_data_ff, read_data_in;

   logic       accept;
   logic [4:0] pos;
   logic       write_ie;

   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign pos      = (char_index_ff > stcp_pkg::LAST_POS) ? stcp_pkg::LAST_POS : char_index_ff;
   assign write_ie = req_chan.write_data[stcp_pkg::CSR_ENABLE_BIT];

   always_comb begin
      rx_done_in       = rx_done_ff;
      rx_enable_in     = rx_enable_ff;
      rx_pending_in    = rx_pending_ff;
      tx_done_in       = tx_done_ff;
      tx_enable_in     = tx_enable_ff;
      tx_pending_in    = tx_pending_ff;
      tx_byte_in       = tx_byte_ff;
      string_loaded_in = string_loaded_ff;
      char_index_in    = char_index_ff;
      digits_in        = digits_ff;
      read_data_in     = 8'd0;

      if (accept) begin
         if (req_chan.func == stcp_pkg::FUNC_READ) begin
            if (req_chan.unit_sel == stcp_pkg::UNIT_RX) begin
               if (req_chan.reg_sel == stcp_pkg::REG_CSR) begin
                  read_data_in = {rx_done_ff, rx_enable_ff, 6'd0};
               end else begin
                  rx_done_in    = 1'b0;
                  rx_pending_in = 1'b0;
                  if (string_loaded_ff) begin
                     read_data_in = stcp_pkg::char_at(pos, digits_ff);
                     // The pointer parks on the final LF; later reads repeat it.
                     if (pos < stcp_pkg::LAST_POS) begin
                        char_index_in = pos + 5'd1;
                        rx_done_in    = 1'b1;
                        rx_pending_in = rx_enable_ff;
                     end
                  end
               end
            end else begin
               if (req_chan.reg_sel == stcp_pkg::REG_CSR) begin
                  read_data_in = {tx_done_ff, tx_enable_ff, 6'd0};
               end else begin
                  read_data_in = tx_byte_ff;
               end
            end
         end else begin
            if (req_chan.reg_sel == stcp_pkg::REG_CSR) begin
               if (!req_chan.byte_high) begin
                  if (req_chan.unit_sel == stcp_pkg::UNIT_RX) begin
                     if (!write_ie) begin
                        rx_pending_in = 1'b0;
                     end else if (rx_done_ff && !rx_enable_ff) begin
                        rx_pending_in = 1'b1;
                     end
                     rx_enable_in = write_ie;
                  end else begin
                     if (!write_ie) begin
                        tx_pending_in = 1'b0;
                     end else if (tx_done_ff && !tx_enable_ff) begin
                        tx_pending_in = 1'b1;
                     end
                     tx_enable_in = write_ie;
                  end
               end
            end else if (req_chan.unit_sel == stcp_pkg::UNIT_TX) begin
               if (!req_chan.byte_high) begin
                  tx_byte_in = req_chan.write_data[7:0];
               end
               // Writing 'T' captures the time and restarts the string, even on an odd byte.
               if (req_chan.write_data[7:0] == stcp_pkg::CHAR_T) begin
                  digits_in        = stcp_pkg::make_digits(req_chan.day_of_year,
                                                           req_chan.hour_now,
                                                           req_chan.minute_now,
                                                           req_chan.second_now);
                  string_loaded_in = 1'b1;
                  char_index_in    = 5'd0;
                  rx_done_in       = 1'b1;
                  if (rx_enable_ff) begin
                     rx_pending_in = 1'b1;
                  end
               end
               tx_done_in    = 1'b1;
               tx_pending_in = tx_enable_ff;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_done_ff       <= 1'b0;
         rx_enable_ff     <= 1'b0;
         rx_pending_ff    <= 1'b0;
         tx_done_ff       <= 1'b1;
         tx_enable_ff     <= 1'b0;
         tx_pending_ff    <= 1'b0;
         tx_byte_ff       <= 8'd0;
         string_loaded_ff <= 1'b0;
         char_index_ff    <= 5'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rx_done_ff       <= rx_done_in;
         rx_enable_ff     <= rx_enable_in;
         rx_pending_ff    <= rx_pending_in;
         tx_done_ff       <= tx_done_in;
         tx_enable_ff     <= tx_enable_in;
         tx_pending_ff    <= tx_pending_in;
         tx_byte_ff       <= tx_byte_in;
         string_loaded_ff <= string_loaded_in;
         char_index_ff    <= char_index_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      if (accept) begin
         read_data_ff <= read_data_in;
      end
   end

   // The interrupt outputs follow the pending flags as left by the last transaction.
   logic rx_irq_ff, tx_irq_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         rx_irq_ff <= rx_pending_in;
         tx_irq_ff <= tx_pending_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = read_data_ff;
   assign rsp_chan.rx_irq    = rx_irq_ff;
   assign rsp_chan.tx_irq    = tx_irq_ff;

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      char_index_ff <= stcp_pkg::LAST_POS)
      else $error("character pointer beyond the end of the string");

   a_index_idle_without_string: assert property (@(posedge clock) disable iff (reset)
      !string_loaded_ff |-> char_index_ff == 5'd0)
      else $error("character pointer moved before a string was loaded");

   a_pending_needs_enable: assert property (@(posedge clock) disable iff (reset)
      (!rx_pending_ff || rx_enable_ff) && (!tx_pending_ff || tx_enable_ff))
      else $error("interrupt pending while its enable is clear");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("transaction accepted while the result register is stalled");

endmodule
